### rtl/core/markup_to_ansi_stream_converter_top_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef MARKUP_TO_ANSI_STREAM_CONVERTER_TOP_DEFINES_SVH
`define MARKUP_TO_ANSI_STREAM_CONVERTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// a implies b in the same cycle
`define M2A_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("m2a check failed");
// a implies b in the next cycle
`define M2A_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("m2a check failed");
`else
`define M2A_ASSERT_IMP(lbl, a, b)
`define M2A_ASSERT_NXT(lbl, a, b)
`endif
`endif

### rtl/core/m2a_pkg.sv
// Types and constants of the markup to ANSI converter.
package m2a_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_M       = 8'h6d;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  // stored tag bytes; names are at most seven bytes after the prefix
  localparam int TAG_STORE = 8;
  localparam int NAME_MAX  = 7;

  // command kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_LIT   = 3'd1;
  localparam logic [2:0] KIND_ATTR  = 3'd2;
  localparam logic [2:0] KIND_COLOR = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_PREFIX = 2'd1;
  localparam logic [1:0] ERR_NAME   = 2'd2;

  localparam logic [7:0] COLOUR_NAME [8][NAME_MAX] = '{
    '{"b", "l", "a", "c", "k", 8'h00, 8'h00},
    '{"r", "e", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "e", "n", 8'h00, 8'h00},
    '{"y", "e", "l", "l", "o", "w", 8'h00},
    '{"b", "l", "u", "e", 8'h00, 8'h00, 8'h00},
    '{"m", "a", "g", "e", "n", "t", "a"},
    '{"c", "y", "a", "n", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "t", "e", 8'h00, 8'h00}
  };
  localparam logic [2:0] COLOUR_LEN [8] = '{
    3'd5, 3'd3, 3'd5, 3'd6, 3'd4, 3'd7, 3'd4, 3'd5
  };

  // one classified input, expanded by the emitter
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] err;
    logic       line_end;
  } cmd_t;

endpackage

### rtl/core/m2a_front.sv
// Front end: accepts input bytes, tracks line and tag state, classifies.
`include "markup_to_ansi_stream_converter_top_defines.svh"
module m2a_front #(
  parameter int LINE_CHUNK = 254,
  parameter int TAG_DEPTH  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_stream,
  input  logic          q_full,
  output logic          q_push,
  output m2a_pkg::cmd_t q_cmd
);
  import m2a_pkg::*;

  localparam int PW = $clog2(LINE_CHUNK + 1);
  localparam int LW = $clog2(TAG_DEPTH + 2);
  localparam int AW = $clog2(TAG_STORE);

  logic          esc_r, esc_nxt;
  logic          tag_open_r, tag_open_nxt;
  logic [LW-1:0] tag_len_r, tag_len_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          drop_r, drop_nxt;
  logic          halted_r, halted_nxt;
  logic [7:0]    tag_text_r [TAG_STORE];
  logic          tag_we;

  logic          accept;
  logic [PW-1:0] pos_inc;
  logic          line_end;
  logic          drop_now;
  logic          is_marker;
  logic [7:0]    marker_digit;
  logic [LW-1:0] name_len;
  logic          hit;
  logic [2:0]    hit_idx;
  logic          chars_ok;
  logic [1:0]    tag_err;
  logic [7:0]    base_digit;
  cmd_t          cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pos_inc  = pos_r + 1'b1;
  assign line_end = (in_byte == CH_LF) || in_end_of_stream || (pos_inc >= PW'(LINE_CHUNK));
  assign drop_now = drop_r || (in_byte == CH_NUL);

  // attribute markers
  always_comb begin
    is_marker    = 1'b1;
    marker_digit = "0";
    unique case (in_byte)
      "$":     marker_digit = "1";
      "!":     marker_digit = "0";
      ">":     marker_digit = "4";
      "~":     marker_digit = "9";
      "/":     marker_digit = "3";
      "*":     marker_digit = "5";
      "&":     marker_digit = "7";
      default: is_marker = 1'b0;
    endcase
  end

  // colour name lookup over the stored tag text
  assign name_len = tag_len_r - 1'b1;
  always_comb begin
    hit     = 1'b0;
    hit_idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      chars_ok = 1'b1;
      for (int j = 0; j < NAME_MAX; j++) begin
        if (3'(j) < COLOUR_LEN[i] && tag_text_r[j+1] != COLOUR_NAME[i][j]) begin
          chars_ok = 1'b0;
        end
      end
      if (!hit && chars_ok && name_len == LW'(COLOUR_LEN[i])) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  // tag check: empty or bad prefix, then overlong or unknown name
  always_comb begin
    base_digit = "3";
    tag_err    = ERR_NONE;
    priority if (tag_len_r == '0) begin
      tag_err = ERR_PREFIX;
    end else if (tag_text_r[0] == "b") begin
      base_digit = "4";
    end else if (tag_text_r[0] != "f") begin
      tag_err = ERR_PREFIX;
    end else begin
      base_digit = "3";
    end
    if (tag_err == ERR_NONE && (tag_len_r > LW'(TAG_DEPTH) || !hit)) begin
      tag_err = ERR_NAME;
    end
  end

  // state update and command build
  always_comb begin
    esc_nxt      = esc_r;
    tag_open_nxt = tag_open_r;
    tag_len_nxt  = tag_len_r;
    pos_nxt      = pos_r;
    drop_nxt     = drop_r;
    halted_nxt   = halted_r;
    tag_we       = 1'b0;
    cmd          = '0;
    cmd.kind     = KIND_NONE;
    if (accept && !halted_r) begin
      drop_nxt = drop_now;
      pos_nxt  = pos_inc;
      if (!drop_now) begin
        priority if (in_byte == CH_BSLASH && !esc_r) begin
          esc_nxt = 1'b1;
        end else if (esc_r) begin
          cmd.kind = KIND_LIT;
          cmd.b0   = in_byte;
          esc_nxt  = 1'b0;
        end else if (in_byte == CH_PERCENT) begin
          tag_len_nxt = '0;
          if (!tag_open_r) begin
            tag_open_nxt = 1'b1;
          end else begin
            tag_open_nxt = 1'b0;
            if (tag_err != ERR_NONE) begin
              cmd.kind   = KIND_ERR;
              cmd.err    = tag_err;
              halted_nxt = 1'b1;
            end else begin
              cmd.kind = KIND_COLOR;
              cmd.b0   = base_digit;
              cmd.b1   = CH_ZERO + {5'd0, hit_idx};
            end
          end
        end else if (tag_open_r) begin
          tag_we = tag_len_r < LW'(TAG_STORE);
          if (tag_len_r <= LW'(TAG_DEPTH)) begin
            tag_len_nxt = tag_len_r + 1'b1;
          end
        end else if (is_marker) begin
          cmd.kind = KIND_ATTR;
          cmd.b0   = marker_digit;
        end else begin
          cmd.kind = KIND_LIT;
          cmd.b0   = in_byte;
        end
      end
      // line end, unless the tag error halted the block
      if (line_end && cmd.kind != KIND_ERR) begin
        cmd.line_end = 1'b1;
        esc_nxt      = 1'b0;
        tag_open_nxt = 1'b0;
        tag_len_nxt  = '0;
        drop_nxt     = 1'b0;
        pos_nxt      = '0;
      end
    end
  end

  assign q_push = (cmd.kind != KIND_NONE) || cmd.line_end;
  assign q_cmd  = cmd;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r      <= 1'b0;
      tag_open_r <= 1'b0;
      tag_len_r  <= '0;
      pos_r      <= '0;
      drop_r     <= 1'b0;
      halted_r   <= 1'b0;
    end else begin
      esc_r      <= esc_nxt;
      tag_open_r <= tag_open_nxt;
      tag_len_r  <= tag_len_nxt;
      pos_r      <= pos_nxt;
      drop_r     <= drop_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // tag text, no reset
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_text_r[tag_len_r[AW-1:0]] <= in_byte;
    end
  end

  `M2A_ASSERT_NXT(a_halt_sticky, halted_r, halted_r)
  `M2A_ASSERT_IMP(a_pos_range, 1'b1, pos_r < PW'(LINE_CHUNK))
  `M2A_ASSERT_IMP(a_halt_no_push, halted_r, !q_push)

endmodule

### rtl/core/m2a_queue.sv
// Short command queue between the front end and the emitter.
module m2a_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  m2a_pkg::cmd_t push_cmd,
  input  logic          pop,
  output m2a_pkg::cmd_t head_cmd,
  output logic          empty,
  output logic          full
);
  import m2a_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/m2a_back.sv
// Emitter: expands queued commands into output bytes, one per cycle while out_stall is low.
`include "markup_to_ansi_stream_converter_top_defines.svh"
module m2a_back (
  input  logic          clk,
  input  logic          rst_n,
  input  m2a_pkg::cmd_t head_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_last_of_run,
  output logic [1:0]    out_error_code
);
  import m2a_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] out_err_r;
  logic       can_load, load;
  logic [2:0] body_len;
  logic [3:0] total;
  logic [3:0] le_idx;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign can_load = !out_valid_r || !out_stall;
  assign load     = can_load && !q_empty;

  // body length per kind, line end adds four bytes
  always_comb begin
    unique case (head_cmd.kind)
      KIND_LIT:   body_len = 3'd1;
      KIND_ATTR:  body_len = 3'd4;
      KIND_COLOR: body_len = 3'd5;
      KIND_ERR:   body_len = 3'd1;
      default:    body_len = 3'd0;
    endcase
  end
  assign total    = {1'b0, body_len} + (head_cmd.line_end ? 4'd4 : 4'd0);
  assign le_idx   = idx_r - {1'b0, body_len};
  assign cur_last = (idx_r == total - 4'd1);

  // byte select
  always_comb begin
    cur_byte = CH_NUL;
    if (idx_r >= {1'b0, body_len}) begin
      unique case (le_idx[1:0])
        2'd0:    cur_byte = ESC_BYTE;
        2'd1:    cur_byte = CH_LBRACK;
        2'd2:    cur_byte = CH_ZERO;
        default: cur_byte = CH_M;
      endcase
    end else begin
      unique case (head_cmd.kind)
        KIND_LIT: cur_byte = head_cmd.b0;
        KIND_ATTR: begin
          unique case (idx_r[1:0])
            2'd0:    cur_byte = ESC_BYTE;
            2'd1:    cur_byte = CH_LBRACK;
            2'd2:    cur_byte = head_cmd.b0;
            default: cur_byte = CH_M;
          endcase
        end
        KIND_COLOR: begin
          unique case (idx_r[2:0])
            3'd0:    cur_byte = ESC_BYTE;
            3'd1:    cur_byte = CH_LBRACK;
            3'd2:    cur_byte = head_cmd.b0;
            3'd3:    cur_byte = head_cmd.b1;
            default: cur_byte = CH_M;
          endcase
        end
        default: cur_byte = CH_NUL;
      endcase
    end
  end

  // step and valid control
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    if (can_load) begin
      out_valid_nxt = !q_empty;
    end
    if (load) begin
      if (cur_last) begin
        idx_nxt = 4'd0;
        q_pop   = 1'b1;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= cur_last;
      out_err_r  <= (head_cmd.kind == KIND_ERR) ? head_cmd.err : ERR_NONE;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_error_code  = out_err_r;

  `M2A_ASSERT_IMP(a_err_is_last, out_valid_r && out_err_r != ERR_NONE, out_last_r)
  `M2A_ASSERT_IMP(a_idx_in_cmd, !q_empty, idx_r < total)
  `M2A_ASSERT_IMP(a_mid_cmd_held, idx_r != 4'd0, !q_empty)

endmodule

### rtl/core/markup_to_ansi_stream_converter_top.sv
// The first result byte of an input passes through the command queue slot, then the output register.
// Throughput: one input per cycle while the 4-entry command queue has room;
// the emitter sends one byte per cycle while out_stall is low, popping a command at its last.
// Sustained rate for plain text is one byte per cycle in and out while out_stall is low.
// Reset: synchronous active-low rst_n clears line, tag and halt state and the queue.
module markup_to_ansi_stream_converter_top #(
  parameter int LINE_CHUNK  = 254,
  parameter int TAG_DEPTH   = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic [1:0] out_error_code
);
  import m2a_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, pop, q_empty, q_full;

  m2a_front #(
    .LINE_CHUNK(LINE_CHUNK),
    .TAG_DEPTH (TAG_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_stream(in_end_of_stream),
    .q_full          (q_full),
    .q_push          (push),
    .q_cmd           (push_cmd)
  );

  m2a_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  m2a_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_cmd       (head_cmd),
    .q_empty        (q_empty),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run),
    .out_error_code (out_error_code)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the markup to ANSI stream converter.
`timescale 1ns / 100ps

module testbench;
  import m2a_pkg::*;

  localparam int LINE_MAX_BYTES = 254;
  localparam int TAG_SLOTS      = 8;
  localparam int MARKUP_TARGET  = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int CYCLE_LIMIT    = 200000;

  // one expected output byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] err;
  } ansi_byte_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} stall_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic [1:0] out_error_code;

  // converter state as seen by the predictor
  logic       esc_pend = 1'b0;
  logic       tag_is_open = 1'b0;
  logic [7:0] tag_buf [TAG_SLOTS];
  int         tag_len = 0;
  int         line_pos = 0;
  logic       dropping = 1'b0;
  logic       conv_halted = 1'b0;
  logic [1:0] halt_err = ERR_NONE;

  ansi_byte_t  ansi_expected[$];
  ansi_byte_t  oldest_expected;
  int          chars_sent = 0;
  int          bytes_checked = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = RX_FREE;

  markup_to_ansi_stream_converter_top #(
    .LINE_CHUNK(LINE_MAX_BYTES),
    .TAG_DEPTH (TAG_SLOTS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_error_code  (out_error_code)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic string colour_name(input int idx);
    case (idx)
      0: return "black";
      1: return "red";
      2: return "green";
      3: return "yellow";
      4: return "blue";
      5: return "magenta";
      6: return "cyan";
      default: return "white";
    endcase
  endfunction

  // attribute digit for a marker character
  function automatic bit marker_digit(input logic [7:0] ch, output logic [7:0] digit);
    digit = "0";
    case (ch)
      "$": digit = "1";
      "!": digit = "0";
      ">": digit = "4";
      "~": digit = "9";
      "/": digit = "3";
      "*": digit = "5";
      "&": digit = "7";
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // decode the collected tag text into an SGR colour number
  function automatic logic [1:0] tag_verdict(output int sgr);
    int    base;
    int    nlen;
    bit    same;
    string name;
    sgr = 0;
    if (tag_len == 0) return ERR_PREFIX;
    if (tag_buf[0] == "b") base = 40;
    else if (tag_buf[0] == "f") base = 30;
    else return ERR_PREFIX;
    if (tag_len > TAG_SLOTS) return ERR_NAME;
    nlen = tag_len - 1;
    for (int c = 0; c < 8; c++) begin
      name = colour_name(c);
      if (name.len() == nlen) begin
        same = 1'b1;
        for (int i = 0; i < nlen; i++)
          if (tag_buf[i + 1] != name[i]) same = 1'b0;
        if (same) begin
          sgr = base + c;
          return ERR_NONE;
        end
      end
    end
    return ERR_NAME;
  endfunction

  // true when this byte would close a tag that decodes to an error
  function automatic bit closes_bad_tag(input logic [7:0] ch);
    int sgr;
    if (conv_halted || dropping || esc_pend || !tag_is_open || ch != CH_PERCENT)
      return 1'b0;
    return tag_verdict(sgr) != ERR_NONE;
  endfunction

  // advance the converter state by one input byte and queue its output
  function automatic void predict_ansi(input logic [7:0] ch, input logic eos);
    logic [7:0] seq[$];
    logic [7:0] digit;
    logic [1:0] verdict;
    bit         line_done;
    int         sgr;
    ansi_byte_t item;
    if (conv_halted) return;
    line_pos++;
    line_done = (ch == CH_LF) || eos || (line_pos >= LINE_MAX_BYTES);
    if (ch == CH_NUL) dropping = 1'b1;
    if (!dropping) begin
      if (ch == CH_BSLASH && !esc_pend) begin
        esc_pend = 1'b1;
      end else if (esc_pend) begin
        seq.push_back(ch);
        esc_pend = 1'b0;
      end else if (ch == CH_PERCENT) begin
        if (!tag_is_open) begin
          tag_is_open = 1'b1;
          tag_len = 0;
        end else begin
          verdict = tag_verdict(sgr);
          tag_is_open = 1'b0;
          tag_len = 0;
          if (verdict != ERR_NONE) begin
            // error: single result, no line end, block stops
            item.data = 8'h00;
            item.last = 1'b1;
            item.err  = verdict;
            ansi_expected.push_back(item);
            conv_halted = 1'b1;
            halt_err = verdict;
            return;
          end
          seq.push_back(ESC_BYTE);
          seq.push_back(CH_LBRACK);
          seq.push_back(CH_ZERO + 8'(sgr / 10));
          seq.push_back(CH_ZERO + 8'(sgr % 10));
          seq.push_back(CH_M);
        end
      end else if (tag_is_open) begin
        if (tag_len < TAG_SLOTS) tag_buf[tag_len] = ch;
        if (tag_len <= TAG_SLOTS) tag_len++;
      end else if (marker_digit(ch, digit)) begin
        seq.push_back(ESC_BYTE);
        seq.push_back(CH_LBRACK);
        seq.push_back(digit);
        seq.push_back(CH_M);
      end else begin
        seq.push_back(ch);
      end
    end
    // line end: reset attributes and clear line state
    if (line_done) begin
      seq.push_back(ESC_BYTE);
      seq.push_back(CH_LBRACK);
      seq.push_back(CH_ZERO);
      seq.push_back(CH_M);
      esc_pend = 1'b0;
      tag_is_open = 1'b0;
      tag_len = 0;
      dropping = 1'b0;
      line_pos = 0;
    end
    for (int i = 0; i < seq.size(); i++) begin
      item.data = seq[i];
      item.last = (i == seq.size() - 1);
      item.err  = ERR_NONE;
      ansi_expected.push_back(item);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // one input transfer, with bursts and random gaps
  task automatic send_char(input logic [7:0] ch, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= ch;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_ansi(ch, eos);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // random stimulus never closes a bad tag; that case is tested on its own
  task automatic send_safe(input logic [7:0] ch, input logic eos);
    if (closes_bad_tag(ch)) ch = "x";
    send_char(ch, eos);
  endtask

  // drop valid, wait for all expected output, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (ansi_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check and stall pattern
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ansi_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b err %0d",
                                  out_byte, out_last_of_run, out_error_code));
      end else begin
        oldest_expected = ansi_expected.pop_front();
        bytes_checked++;
        if (out_byte !== oldest_expected.data)
          report_mismatch($sformatf("byte %02h, expected %02h",
                                    out_byte, oldest_expected.data));
        if (out_last_of_run !== oldest_expected.last)
          report_mismatch($sformatf("last_of_run %0b, expected %0b (byte %02h)",
                                    out_last_of_run, oldest_expected.last, out_byte));
        if (out_error_code !== oldest_expected.err)
          report_mismatch($sformatf("error_code %0d, expected %0d",
                                    out_error_code, oldest_expected.err));
      end
    end
    // stall pattern changes mode every so often
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
      default:  out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // plain text and every attribute marker
  task automatic test_markers();
    send_text("A$!>~/*&\n");
    wait_idle();
  endtask

  // escapes, escaped byte inside a tag, newline inside a tag
  task automatic test_escapes_and_tags();
    send_text("%\\xbred%");
    send_text("\\%");
    send_text("%f\n");
    wait_idle();
  endtask

  // zero byte drops the rest of its line; open escape at stream end
  task automatic test_dropped_line();
    send_text("q");
    send_char(CH_NUL, 1'b0);
    send_text("%");
    send_char("k", 1'b1);
    send_char(CH_BSLASH, 1'b1);
    wait_idle();
  endtask

  // a line longer than the chunk size splits at the limit
  task automatic test_line_chunk();
    logic [7:0] ch;
    for (int i = 0; i < 300; i++) begin
      ch = 8'($urandom_range(8'h20, 8'h7e));
      if (ch == CH_PERCENT || ch == CH_BSLASH) ch = ".";
      send_char(ch, 1'b0);
    end
    send_char(CH_LF, 1'b0);
    wait_idle();
  endtask

  // one random piece of markup, mostly well formed
  task automatic send_markup_piece();
    int         n;
    int         cut;
    logic [7:0] ch;
    string      name;
    string      marks;
    marks = "$!>~/*&";
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          ch = 8'($urandom_range(8'h20, 8'h7e));
          if (ch == CH_PERCENT) ch = ".";
          send_safe(ch, 1'b0);
        end
      end
      5, 6: send_safe(marks[$urandom_range(0, 6)], 1'b0);
      7, 8: begin
        send_safe(CH_BSLASH, 1'b0);
        send_safe(8'($urandom_range(0, 255)), 1'b0);
      end
      9, 10, 11: begin
        name = colour_name($urandom_range(0, 7));
        send_safe(CH_PERCENT, 1'b0);
        send_safe($urandom_range(0, 1) ? "f" : "b", 1'b0);
        for (int i = 0; i < name.len(); i++) send_safe(name[i], 1'b0);
        send_safe(CH_PERCENT, 1'b0);
      end
      12: begin
        // escaped byte in the middle of a good tag
        name = colour_name($urandom_range(0, 7));
        cut = $urandom_range(0, name.len());
        send_safe(CH_PERCENT, 1'b0);
        send_safe($urandom_range(0, 1) ? "f" : "b", 1'b0);
        for (int i = 0; i < cut; i++) send_safe(name[i], 1'b0);
        send_safe(CH_BSLASH, 1'b0);
        send_safe(8'($urandom_range(1, 255)), 1'b0);
        for (int i = cut; i < name.len(); i++) send_safe(name[i], 1'b0);
        send_safe(CH_PERCENT, 1'b0);
      end
      13, 14: send_safe(CH_LF, 1'b0);
      15: send_safe(CH_NUL, 1'b0);
      16: send_safe(8'($urandom_range(0, 255)), 1'b1);
      17: send_safe(8'($urandom_range(0, 255)), 1'b0);
      18: begin
        // tag that seldom closes cleanly
        n = $urandom_range(1, 10);
        send_safe(CH_PERCENT, 1'b0);
        for (int i = 0; i < n; i++) send_safe(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
        send_safe(CH_LF, 1'b0);
      end
      default: begin
        send_safe(CH_PERCENT, 1'b0);
        send_safe("f", 1'b0);
        send_safe("r", 1'b0);
        send_safe(CH_LF, 1'b0);
      end
    endcase
  endtask

  task automatic test_random_markup();
    while (chars_sent < MARKUP_TARGET) send_markup_piece();
    send_safe(CH_LF, 1'b0);
    wait_idle();
  endtask

  // bad tag gives an error and the block ignores all later input
  task automatic test_halt_on_bad_tag();
    send_char(CH_LF, 1'b0);
    case ($urandom_range(0, 3))
      0: send_text("%%");
      1: send_text("%xred%");
      2: send_text("%fpink%");
      default: send_text("%bmagentamagenta%");
    endcase
    send_text("$ok\n");
    send_char("z", 1'b1);
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < TAG_SLOTS; i++) tag_buf[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_markers();
    test_escapes_and_tags();
    test_dropped_line();
    test_line_chunk();
    test_random_markup();
    test_halt_on_bad_tag();

    $display("summary: %0d input transfers, %0d output bytes checked, %0d mismatches",
             chars_sent, bytes_checked, mismatches);
    $display("summary: markers, escapes, colour tags, dropped and split lines, halt on error %0d",
             halt_err);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
